>>> hw/rtl/tw_odo_pkg.sv
// Package for the two-wheel odometry step: widths, fixed-point constants, sequencer
// state codes, the quarter-wave sine table and the position accumulate function.
// Depends on nothing; tw_odo_mul, tw_odo_seq and the top level import it.
package tw_odo_pkg;

    // Fraction bits of the sine table.
    localparam int TRIG_FRAC_BITS = 15;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 1;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // pi/180 in Q30.
    localparam logic [24:0] DEG2RAD_Q30 = 25'd18740330;

    // Division by 100 as a multiply by a reciprocal; exact for magnitudes below 91180.
    localparam logic [16:0] K100       = 17'd83887;
    localparam int          K100_SHIFT = 23;

    // Wheel distance: deg * radius_q8 * DEG2RAD_Q30 >> 38.
    localparam int DIST_SHIFT = 38;
    localparam int DIST_W     = 13;
    localparam int TMP_W      = 26;

    localparam logic [15:0] RADIUS_RESET = 16'd6502;

    // Heading constants in degrees.
    localparam int QUARTER_DEG = 90;
    localparam int HALF_DEG    = 180;
    localparam int FULL_DEG    = 360;

    // Width of |step| * trig and of the shifted accumulator sum.
    localparam int TPROD_W = 16 + TRIG_W;
    localparam int SUM_W   = 34 + TRIG_FRAC_BITS;
    localparam int RES_W   = SUM_W - TRIG_FRAC_BITS;

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIVA = 4'd1;
    localparam logic [3:0] ST_DIVB = 4'd2;
    localparam logic [3:0] ST_RADA = 4'd3;
    localparam logic [3:0] ST_RADB = 4'd4;
    localparam logic [3:0] ST_D2RA = 4'd5;
    localparam logic [3:0] ST_D2RB = 4'd6;
    localparam logic [3:0] ST_STEP = 4'd7;
    localparam logic [3:0] ST_MULX = 4'd8;
    localparam logic [3:0] ST_MULY = 4'd9;
    localparam logic [3:0] ST_ACCY = 4'd10;

    typedef struct packed {
        logic [3:0] state;
        logic       in_ready;
        logic       accept;
        logic       issue;
        logic       finish;
    } seq_ctrl_t;

    typedef logic [TRIG_W-1:0] trig_tab_t [0:QUARTER_DEG];

    // Taylor series divisors (2k)(2k+1) for k = 1..9.
    localparam logic [63:0] TAYLOR_DIV [0:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
    };

    localparam logic signed [63:0] HALF_LSB  = 64'sd1 <<< (29 - TRIG_FRAC_BITS);
    localparam logic signed [63:0] ONE_Q30   = 64'sd1 <<< 30;

    // Builds sin(d deg) for d = 0..90 at elaboration: odd series through x^19 in Q30.
    function automatic trig_tab_t build_trig_tab();
        trig_tab_t         tab;
        logic [63:0]       x;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic signed [63:0] sum;
        for (int d = 0; d <= QUARTER_DEG; d++) begin
            x    = 64'(d) * 64'(DEG2RAD_Q30);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int k = 1; k <= 9; k++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
                if ((k % 2) == 1) begin
                    sum = sum - $signed(term);
                end
                else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            if (sum > ONE_Q30) begin
                sum = ONE_Q30;
            end
            tab[d] = TRIG_W'((sum + HALF_LSB) >>> (30 - TRIG_FRAC_BITS));
        end
        return tab;
    endfunction

    localparam trig_tab_t TRIG_TAB = build_trig_tab();

    localparam logic signed [SUM_W-1:0] TRUNC_ADJ = SUM_W'((64'sd1 <<< TRIG_FRAC_BITS) - 1);

    // acc' = trunc_toward_zero(((acc << F) +/- prod) / 2^F), saturated to 32 bits.
    function automatic logic signed [31:0] acc_update(
        logic signed [31:0]  acc,
        logic [TPROD_W-1:0]  prod,
        logic                neg
    );
        logic signed [SUM_W-1:0] p;
        logic signed [SUM_W-1:0] s;
        logic signed [RES_W-1:0] r;
        logic signed [31:0]      res;
        p = $signed(SUM_W'(prod));
        if (neg) begin
            p = -p;
        end
        s = ($signed(SUM_W'(acc)) <<< TRIG_FRAC_BITS) + p;
        if (s[SUM_W-1]) begin
            s = s + TRUNC_ADJ;
        end
        r = RES_W'(s >>> TRIG_FRAC_BITS);
        if (r[RES_W-1:31] != {(RES_W-31){r[RES_W-1]}}) begin
            res = r[RES_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else begin
            res = r[31:0];
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/tw_odo_ifs.sv
// Handshake channels of the two-wheel odometry step: sample input, result output
// and the wheel radius configuration write. Depends on nothing.

interface tw_odo_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        wheel_a_angle;
    logic [15:0]        wheel_b_angle;
    logic signed [9:0]  heading_deg;

    modport source (output valid, output wheel_a_angle, output wheel_b_angle,
                    output heading_deg, input ready);
    modport sink   (input valid, input wheel_a_angle, input wheel_b_angle,
                    input heading_deg, output ready);
endinterface

interface tw_odo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x_mm;
    logic signed [31:0] pos_y_mm;
    logic signed [15:0] step_mm;
    logic signed [8:0]  heading_wrapped;

    modport source (output valid, output pos_x_mm, output pos_y_mm, output step_mm,
                    output heading_wrapped, input ready);
    modport sink   (input valid, input pos_x_mm, input pos_y_mm, input step_mm,
                    input heading_wrapped, output ready);
endinterface

interface tw_odo_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] wheel_radius_q8;

    modport source (output valid, output wheel_radius_q8, input ready);
    modport sink   (input valid, input wheel_radius_q8, output ready);
endinterface

>>> hw/rtl/tw_odo_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on tw_odo_pkg for the operand and product widths.
module tw_odo_mul (
    input  logic                        clk,
    input  logic                        issue,
    input  logic [tw_odo_pkg::MUL_W-1:0]  op_a,
    input  logic [tw_odo_pkg::MUL_W-1:0]  op_b,
    output logic [tw_odo_pkg::PROD_W-1:0] prod
);
    import tw_odo_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // The product holds while no multiply is issued.
    always_ff @(posedge clk) begin
        if (issue) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

>>> hw/rtl/tw_odo_seq.sv
// Sequencer of the odometry step: walks one item through the multiply schedule.
// Depends on tw_odo_pkg for the state codes and the control struct.
module tw_odo_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   out_free,
    output tw_odo_pkg::seq_ctrl_t  ctrl
);
    import tw_odo_pkg::*;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_DIVA;
            ST_DIVA: state_next = ST_DIVB;
            ST_DIVB: state_next = ST_RADA;
            ST_RADA: state_next = ST_RADB;
            ST_RADB: state_next = ST_D2RA;
            ST_D2RA: state_next = ST_D2RB;
            ST_D2RB: state_next = ST_STEP;
            ST_STEP: state_next = ST_MULX;
            ST_MULX: state_next = ST_MULY;
            ST_MULY: state_next = ST_ACCY;
            ST_ACCY: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        ctrl.state    = state_reg;
        ctrl.in_ready = (state_reg == ST_IDLE);
        ctrl.accept   = in_valid && (state_reg == ST_IDLE);
        ctrl.finish   = out_free && (state_reg == ST_ACCY);
        unique case (state_reg) inside
            ST_DIVA, ST_DIVB, ST_RADA, ST_RADB, ST_D2RA, ST_D2RB, ST_MULX, ST_MULY:
                ctrl.issue = 1'b1;
            default:
                ctrl.issue = 1'b0;
        endcase
    end

endmodule

>>> hw/rtl/two_wheel_odometry_step.sv
// Top level of the two-wheel odometry step: datapath registers, operand selection
// for the shared multiplier, and the result register.
// Depends on tw_odo_pkg, the channel interfaces, tw_odo_mul and tw_odo_seq.
//
// Usage:
// The sample channel carries two raw tracking-wheel angles in centidegrees and a
// heading in whole degrees. Each accepted item yields exactly one item on the
// result channel: the accumulated X and Y positions, the averaged step in
// millimeters and the wrapped heading. The cfg channel writes the Q8.8 wheel
// radius; it is always ready and should be written only while the block is idle.
// The block works on one item at a time: it takes no new item until the last one
// has passed its final step. The eight products run one after another through
// the single shared multiplier, followed by the averaging step and the final
// accumulate step. sample.ready is high only while the sequencer is idle. The
// result sits in an output register, so the block accepts the next item while a
// result is still waiting; if the receiver stalls, the next item stops in its
// final step until the register frees up. Reset clears the previous angles,
// stored changes and positions, and loads the default radius.
module two_wheel_odometry_step (
    input  logic          clk,
    input  logic          rst_n,
    tw_odo_in_if.sink     sample,
    tw_odo_out_if.source  result,
    tw_odo_cfg_if.sink    cfg
);
    import tw_odo_pkg::*;

    seq_ctrl_t          ctrl;
    logic               out_free;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;

    // Architectural state.
    logic [15:0]        radius_reg;
    logic [15:0]        prev_a_reg;
    logic [15:0]        prev_b_reg;
    logic signed [16:0] chg_a_reg;
    logic signed [16:0] chg_b_reg;
    logic signed [31:0] acc_x_reg;
    logic signed [31:0] acc_y_reg;
    logic               out_valid_reg;

    // Per-item working registers.
    logic signed [8:0]  h_reg;
    logic [TRIG_W-1:0]  cos_reg;
    logic [TRIG_W-1:0]  sin_reg;
    logic               cos_neg_reg;
    logic               sin_neg_reg;
    logic [TMP_W-1:0]   t_a_reg;
    logic [TMP_W-1:0]   t_b_reg;
    logic [DIST_W-1:0]  dist_a_reg;
    logic signed [15:0] step_reg;

    // Result payload.
    logic signed [31:0] pos_x_reg;
    logic signed [31:0] pos_y_reg;
    logic signed [15:0] step_out_reg;
    logic signed [8:0]  heading_out_reg;

    logic signed [16:0] chg_a_new;
    logic signed [16:0] chg_b_new;
    logic signed [10:0] h_wide;
    logic signed [8:0]  h_next;
    logic [7:0]         h_abs;
    logic [6:0]         cos_idx;
    logic [6:0]         sin_idx;
    logic               cos_neg;
    logic [16:0]        mag_a;
    logic [16:0]        mag_b;
    logic [15:0]        step_mag;
    logic [DIST_W-1:0]  dist_b;
    logic signed [DIST_W+1:0] dist_a_s;
    logic signed [DIST_W+1:0] dist_b_s;
    logic signed [DIST_W+1:0] dist_sum;
    logic signed [15:0] step_next;
    logic signed [31:0] acc_x_next;
    logic signed [31:0] acc_y_next;

    tw_odo_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    tw_odo_mul u_mul (
        .clk   (clk),
        .issue (ctrl.issue),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .prod  (mul_p)
    );

    assign sample.ready = ctrl.in_ready;
    assign cfg.ready    = 1'b1;
    assign out_free     = !out_valid_reg || result.ready;

    // Wheel changes against the previous reading, formed at acceptance.
    assign chg_a_new = $signed({1'b0, sample.wheel_a_angle}) - $signed({1'b0, prev_a_reg});
    assign chg_b_new = $signed({1'b0, sample.wheel_b_angle}) - $signed({1'b0, prev_b_reg});

    // One wrap correction brings any 10-bit heading into -180..180.
    always_comb begin
        h_wide = 11'(sample.heading_deg);
        if (h_wide > 11'sd180) begin
            h_wide = h_wide - 11'(FULL_DEG);
        end
        if (h_wide < -11'sd180) begin
            h_wide = h_wide + 11'(FULL_DEG);
        end
        h_next = 9'(h_wide);
    end

    // Quadrant folding of the wrapped heading onto the quarter-wave table.
    always_comb begin
        h_abs = h_reg[8] ? 8'(-h_reg) : 8'(h_reg);
        if (h_abs <= 8'(QUARTER_DEG)) begin
            cos_idx = 7'(8'(QUARTER_DEG) - h_abs);
            sin_idx = h_abs[6:0];
            cos_neg = 1'b0;
        end
        else begin
            cos_idx = 7'(h_abs - 8'(QUARTER_DEG));
            sin_idx = 7'(8'(HALF_DEG) - h_abs);
            cos_neg = 1'b1;
        end
    end

    assign mag_a    = chg_a_reg[16] ? 17'(-chg_a_reg) : 17'(chg_a_reg);
    assign mag_b    = chg_b_reg[16] ? 17'(-chg_b_reg) : 17'(chg_b_reg);
    assign step_mag = step_reg[15] ? 16'(-step_reg) : 16'(step_reg);

    // Both wheel distances carry the sign of their change; the average truncates
    // toward zero by adding one to a negative sum before the arithmetic shift.
    always_comb begin
        dist_b   = DIST_W'(mul_p >> DIST_SHIFT);
        dist_a_s = chg_a_reg[16] ? -$signed((DIST_W+2)'(dist_a_reg))
                                 : $signed((DIST_W+2)'(dist_a_reg));
        dist_b_s = chg_b_reg[16] ? -$signed((DIST_W+2)'(dist_b))
                                 : $signed((DIST_W+2)'(dist_b));
        dist_sum = dist_a_s + dist_b_s;
        step_next = 16'((dist_sum + $signed((DIST_W+2)'(dist_sum[DIST_W+1]))) >>> 1);
    end

    assign acc_x_next = acc_update(acc_x_reg, mul_p[TPROD_W-1:0], step_reg[15] ^ cos_neg_reg);
    assign acc_y_next = acc_update(acc_y_reg, mul_p[TPROD_W-1:0], step_reg[15] ^ sin_neg_reg);

    // Operand selection for the shared multiplier. The two wheels interleave so
    // each product is registered before the next step uses it.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.state)
            ST_DIVA: begin
                mul_a = MUL_W'(mag_a);
                mul_b = MUL_W'(K100);
            end
            ST_DIVB: begin
                mul_a = MUL_W'(mag_b);
                mul_b = MUL_W'(K100);
            end
            ST_RADA: begin
                mul_a = MUL_W'(t_a_reg);
                mul_b = MUL_W'(radius_reg);
            end
            ST_RADB: begin
                mul_a = MUL_W'(t_b_reg);
                mul_b = MUL_W'(radius_reg);
            end
            ST_D2RA: begin
                mul_a = MUL_W'(t_a_reg);
                mul_b = MUL_W'(DEG2RAD_Q30);
            end
            ST_D2RB: begin
                mul_a = MUL_W'(t_b_reg);
                mul_b = MUL_W'(DEG2RAD_Q30);
            end
            ST_MULX: begin
                mul_a = MUL_W'(step_mag);
                mul_b = MUL_W'(cos_reg);
            end
            ST_MULY: begin
                mul_a = MUL_W'(step_mag);
                mul_b = MUL_W'(sin_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // State that the model carries from item to item.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            radius_reg    <= RADIUS_RESET;
            prev_a_reg    <= '0;
            prev_b_reg    <= '0;
            chg_a_reg     <= '0;
            chg_b_reg     <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cfg.valid) begin
                radius_reg <= cfg.wheel_radius_q8;
            end
            if (ctrl.accept) begin
                // An unchanged reading keeps the last nonzero change.
                if (sample.wheel_a_angle != prev_a_reg) begin
                    chg_a_reg <= chg_a_new;
                end
                if (sample.wheel_b_angle != prev_b_reg) begin
                    chg_b_reg <= chg_b_new;
                end
                prev_a_reg <= sample.wheel_a_angle;
                prev_b_reg <= sample.wheel_b_angle;
            end
            if (ctrl.state == ST_MULY) begin
                acc_x_reg <= acc_x_next;
            end
            if (ctrl.finish) begin
                acc_y_reg     <= acc_y_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk) begin
        if (ctrl.accept) begin
            h_reg <= h_next;
        end
        case (ctrl.state)
            ST_DIVA: begin
                cos_reg     <= TRIG_TAB[cos_idx];
                sin_reg     <= TRIG_TAB[sin_idx];
                cos_neg_reg <= cos_neg;
                sin_neg_reg <= h_reg[8];
            end
            ST_DIVB: t_a_reg    <= TMP_W'(mul_p >> K100_SHIFT);
            ST_RADA: t_b_reg    <= TMP_W'(mul_p >> K100_SHIFT);
            ST_RADB: t_a_reg    <= mul_p[TMP_W-1:0];
            ST_D2RA: t_b_reg    <= mul_p[TMP_W-1:0];
            ST_D2RB: dist_a_reg <= DIST_W'(mul_p >> DIST_SHIFT);
            ST_STEP: step_reg   <= step_next;
            default: ;
        endcase
        if (ctrl.finish) begin
            pos_x_reg       <= acc_x_reg;
            pos_y_reg       <= acc_y_next;
            step_out_reg    <= step_reg;
            heading_out_reg <= h_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.pos_x_mm        = pos_x_reg;
    assign result.pos_y_mm        = pos_y_reg;
    assign result.step_mm         = step_out_reg;
    assign result.heading_wrapped = heading_out_reg;

endmodule

>>> hw/rtl/tw_odo_chk.sv
// Port-level checker for the two-wheel odometry step and its bind to the top level.
// Depends on the channel interfaces.
module tw_odo_chk (
    input logic          clk,
    input logic          rst_n,
    tw_odo_in_if.sink    sample,
    tw_odo_out_if.source result,
    tw_odo_cfg_if.sink   cfg
);

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("sample accepted while a previous item is in work");

    // A result never shows up the cycle right after an item is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !$rose(result.valid))
        else $error("result appeared too early");

    // The reported heading always lies in the wrapped range.
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.heading_wrapped >= -9'sd180) &&
                         (result.heading_wrapped <= 9'sd180))
        else $error("heading out of wrapped range");

    // A stalled result holds its positions and its step.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.pos_x_mm) &&
            $stable(result.pos_y_mm) && $stable(result.step_mm))
        else $error("stalled result changed");

    // The radius write channel never stalls.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |-> cfg.ready)
        else $error("radius write stalled");

endmodule

bind two_wheel_odometry_step tw_odo_chk u_tw_odo_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
);

>>> tb/sv/tb.sv
// Self-checking testbench for two_wheel_odometry_step: directed and random wheel samples,
// radius writes, random idling on both channels and a long output stall.
// Depends on tw_odo_pkg and the channel interfaces in tw_odo_ifs.sv.
module tb;

    // Fraction bits of the sine table, taken from the block's package.
    localparam int TRIG_FRAC = tw_odo_pkg::TRIG_FRAC_BITS;
    localparam longint TRIG_ONE = longint'(1) << TRIG_FRAC;
    // pi/180 in Q30, the scale used for both the wheel distance and the sine series.
    localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;
    localparam logic [15:0] RESET_RADIUS = 16'd6502;

    localparam int MAX_GAP        = 11;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // One expected result item.
    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] step;
        logic signed [8:0]  heading;
    } odo_fix_t;

    logic clk;
    logic rst_n;

    tw_odo_in_if  sample_ch ();
    tw_odo_out_if result_ch ();
    tw_odo_cfg_if cfg_ch ();

    two_wheel_odometry_step DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predictor state: the last raw angles, the last nonzero changes, the two
    // positions and the radius currently held in the block.
    logic [15:0]        prev_a;
    logic [15:0]        prev_b;
    int                 last_chg_a;
    int                 last_chg_b;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        radius_q8;

    // sin(d degrees) for d = 0..90 with TRIG_FRAC fraction bits, built from the same
    // truncated Taylor series that the block uses, so the values match bit for bit.
    logic [TRIG_FRAC:0] sine_tab [0:90];

    odo_fix_t           pending_fixes [$];

    int fix_errors;
    int fixes_checked;
    int samples_taken;
    int radius_writes;
    int idle_cycles;

    // Idling controls shared by the tests and the channel drivers.
    int src_gap_max;
    int rcv_gap_max;
    int result_hold_cycles;

    // Random walk of the robot used by the motion generator.
    logic [15:0] walk_a;
    logic [15:0] walk_b;
    int          walk_h;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Converts one wheel's change in centidegrees into millimeters: the change is
    // truncated to whole degrees, then scaled by the Q8.8 radius and pi/180.
    function automatic int wheel_travel(int chg);
        int              deg;
        longint unsigned mag;
        longint unsigned prod;
        deg  = chg / 100;
        mag  = (deg < 0) ? longint'(-deg) : longint'(deg);
        prod = (mag * longint'(radius_q8) * RAD_PER_DEG_Q30) >> 38;
        return (deg < 0) ? -int'(prod) : int'(prod);
    endfunction

    // Adds step * trig to a position held with TRIG_FRAC extra fraction bits,
    // truncates toward zero and saturates to the signed 32-bit range.
    function automatic logic signed [31:0] advance_pos(logic signed [31:0] pos, int step,
                                                       longint trig);
        longint sum;
        longint res;
        sum = longint'(pos) * TRIG_ONE + longint'(step) * trig;
        res = sum / TRIG_ONE;
        if (res > longint'(32'sh7fff_ffff)) begin
            res = longint'(32'sh7fff_ffff);
        end
        if (res < longint'(32'sh8000_0000)) begin
            res = longint'(32'sh8000_0000);
        end
        return 32'(res);
    endfunction

    // Advances the predicted odometry by one accepted sample item and returns
    // the result item that the block must produce for it.
    function automatic odo_fix_t predict_odometry(logic [15:0] a, logic [15:0] b,
                                                  logic signed [9:0] hdg);
        odo_fix_t fix;
        int       hh;
        int       mag_h;
        int       step;
        longint   cos_v;
        longint   sin_v;
        hh = int'(hdg);
        // An unchanged reading leaves the stored change as it was.
        if (a != prev_a) begin
            last_chg_a = int'(a) - int'(prev_a);
        end
        prev_a = a;
        if (b != prev_b) begin
            last_chg_b = int'(b) - int'(prev_b);
        end
        prev_b = b;
        step = (wheel_travel(last_chg_a) + wheel_travel(last_chg_b)) / 2;
        // A single wrapping correction.
        if (hh > 180) begin
            hh = hh - 360;
        end
        if (hh < -180) begin
            hh = hh + 360;
        end
        mag_h = (hh < 0) ? -hh : hh;
        if (mag_h <= 90) begin
            cos_v = longint'(sine_tab[90 - mag_h]);
            sin_v = longint'(sine_tab[mag_h]);
        end
        else begin
            cos_v = -longint'(sine_tab[mag_h - 90]);
            sin_v = longint'(sine_tab[180 - mag_h]);
        end
        if (hh < 0) begin
            sin_v = -sin_v;
        end
        pos_x = advance_pos(pos_x, step, cos_v);
        pos_y = advance_pos(pos_y, step, sin_v);
        fix.pos_x   = pos_x;
        fix.pos_y   = pos_y;
        fix.step    = 16'(step);
        fix.heading = 9'(hh);
        return fix;
    endfunction

    // Offers one sample item after a random gap and holds it until the block takes it.
    // Valid is left high afterwards, so back-to-back items never drop it.
    task automatic send_sample(input logic [15:0] a, input logic [15:0] b, input int hdg);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        repeat (gap) begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
        end
        @(negedge clk);
        sample_ch.valid         <= 1'b1;
        sample_ch.wheel_a_angle <= a;
        sample_ch.wheel_b_angle <= b;
        sample_ch.heading_deg   <= 10'(hdg);
        do begin
            @(posedge clk);
        end while (!(sample_ch.valid && sample_ch.ready));
    endtask

    // Stops offering items, waits until every result item has arrived, then
    // gives the sequencer time to return to idle.
    task automatic settle_block();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (pending_fixes.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the wheel radius; only called while the block is idle.
    task automatic write_radius(input logic [15:0] value);
        @(negedge clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.wheel_radius_q8 <= value;
        do begin
            @(posedge clk);
        end while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random motion: mostly a smooth walk of both wheels and the heading, some
    // items with one or both wheels standing still, and the rest fully random
    // readings that exercise every bit and the large raw-angle jumps.
    task automatic drive_motion(input int count);
        int mode;
        int delta;
        int which;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 99);
            if (mode < 60) begin
                delta  = int'($urandom_range(0, 4000)) - 2000;
                walk_a = 16'(int'(walk_a) + delta);
                walk_b = 16'(int'(walk_b) + delta + int'($urandom_range(0, 400)) - 200);
                walk_h = walk_h + int'($urandom_range(0, 20)) - 10;
                if (walk_h > 360) begin
                    walk_h = 360;
                end
                if (walk_h < -360) begin
                    walk_h = -360;
                end
            end
            else if (mode < 75) begin
                which = $urandom_range(0, 2);
                if (which == 0) begin
                    walk_a = 16'(int'(walk_a) + int'($urandom_range(0, 600)) - 300);
                end
                else if (which == 1) begin
                    walk_b = 16'(int'(walk_b) + int'($urandom_range(0, 600)) - 300);
                end
            end
            else begin
                walk_a = 16'($urandom);
                walk_b = 16'($urandom);
                walk_h = int'($urandom_range(0, 720)) - 360;
            end
            send_sample(walk_a, walk_b, walk_h);
        end
    endtask

    // Right after reset both wheels read zero, so both stored changes stay at
    // their reset value of zero and the robot must not move.
    task automatic test_still_wheels();
        src_gap_max = MAX_GAP;
        rcv_gap_max = MAX_GAP;
        send_sample(16'd0, 16'd0, 0);
        send_sample(16'd0, 16'd0, 45);
    endtask

    // Full-scale raw jumps in both directions, repeated readings that reuse the
    // stored change, changes just below and at one whole degree, and mid-scale.
    task automatic test_wheel_extremes();
        send_sample(16'd65535, 16'd0, 0);
        send_sample(16'd0, 16'd65535, 0);
        send_sample(16'd0, 16'd65535, 90);
        send_sample(16'd99, 16'd65436, 0);
        send_sample(16'd199, 16'd65336, -90);
        send_sample(16'd32768, 16'd32767, 180);
        send_sample(16'd32767, 16'd32768, -180);
        send_sample(16'd65535, 16'd65535, 0);
    endtask

    // Headings at the range ends, around both wrap points and near every quadrant
    // boundary, with both wheels moving so that each item produces travel.
    task automatic test_heading_wrap();
        int headings [15] = '{-360, -181, -180, -179, -91, -90, -1, 0, 1, 91,
                              179, 180, 181, 359, 360};
        logic [15:0] a;
        logic [15:0] b;
        a = 16'd1000;
        b = 16'd2000;
        src_gap_max = 0;
        rcv_gap_max = 0;
        foreach (headings[i]) begin
            a = a + 16'd1234;
            b = b + 16'd1100;
            send_sample(a, b, headings[i]);
        end
    endtask

    // Runs motion under several radii: zero, full scale, the smallest nonzero
    // value, a random one, and finally the reset default again.
    task automatic test_radius_settings();
        logic [15:0] radii [5];
        radii = '{16'd0, 16'd65535, 16'd1, 16'($urandom), RESET_RADIUS};
        src_gap_max = MAX_GAP;
        rcv_gap_max = MAX_GAP;
        foreach (radii[i]) begin
            settle_block();
            write_radius(radii[i]);
            drive_motion(40);
        end
    endtask

    // The bulk of the random items, in chunks with different idling on each side,
    // including stretches with no idling at all.
    task automatic test_motion_random();
        src_gap_max = MAX_GAP;
        rcv_gap_max = MAX_GAP;
        drive_motion(175);
        src_gap_max = 0;
        rcv_gap_max = MAX_GAP;
        drive_motion(175);
        src_gap_max = MAX_GAP;
        rcv_gap_max = 0;
        drive_motion(175);
        src_gap_max = 0;
        rcv_gap_max = 0;
        drive_motion(175);
    endtask

    // The sender first waits until the block is empty, then the receiver holds
    // off for a long stretch while items keep coming back to back, so the result
    // register fills and the block stalls its sample input.
    task automatic test_result_backpressure();
        settle_block();
        src_gap_max        = 0;
        rcv_gap_max        = MAX_GAP;
        result_hold_cycles = HOLD_CYCLES;
        drive_motion(30);
        settle_block();
    endtask

    // Result ready: after every accepted result item the receiver draws a stall,
    // and a long hold requested by a test is counted down here cycle by cycle.
    initial begin : result_ready_driver
        int stall;
        bit took;
        result_ch.ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge clk);
            took = result_ch.valid && result_ch.ready;
            @(negedge clk);
            if (took) begin
                stall = $urandom_range(0, rcv_gap_max);
            end
            if (result_hold_cycles > 0) begin
                result_hold_cycles--;
                result_ch.ready <= 1'b0;
            end
            else if (stall > 0) begin
                stall--;
                result_ch.ready <= 1'b0;
            end
            else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Every sample item the block accepts is run through the predictor at once.
    always @(posedge clk) begin
        if (rst_n && sample_ch.valid && sample_ch.ready) begin
            pending_fixes.push_back(predict_odometry(sample_ch.wheel_a_angle,
                                                     sample_ch.wheel_b_angle,
                                                     sample_ch.heading_deg));
            samples_taken++;
        end
    end

    // Radius writes take effect in the predictor at the same edge as in the block.
    always @(posedge clk) begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
            radius_q8 = cfg_ch.wheel_radius_q8;
            radius_writes++;
        end
    end

    // Each result item is compared, field by field, with the oldest prediction.
    always @(posedge clk) begin : fix_checker
        odo_fix_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_fixes.size() == 0) begin
                fix_errors++;
                if (fix_errors <= REPORT_LIMIT) begin
                    $display("Unexpected result: x=%0d y=%0d step=%0d heading=%0d",
                             result_ch.pos_x_mm, result_ch.pos_y_mm,
                             result_ch.step_mm, result_ch.heading_wrapped);
                end
            end
            else begin
                want = pending_fixes.pop_front();
                if (want.pos_x !== result_ch.pos_x_mm || want.pos_y !== result_ch.pos_y_mm ||
                    want.step !== result_ch.step_mm ||
                    want.heading !== result_ch.heading_wrapped) begin
                    fix_errors++;
                    if (fix_errors <= REPORT_LIMIT) begin
                        $display("Result %0d mismatch: expected x=%0d y=%0d step=%0d heading=%0d",
                                 fixes_checked, want.pos_x, want.pos_y, want.step,
                                 want.heading);
                        $display("    got x=%0d y=%0d step=%0d heading=%0d",
                                 result_ch.pos_x_mm, result_ch.pos_y_mm,
                                 result_ch.step_mm, result_ch.heading_wrapped);
                    end
                end
                fixes_checked++;
            end
        end
    end

    // The run is stopped if no handshake of any kind happens for too long.
    always @(posedge clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end
        else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;

        // Every input of the block is at a known value from time zero.
        rst_n                   = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.wheel_a_angle = '0;
        sample_ch.wheel_b_angle = '0;
        sample_ch.heading_deg   = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.wheel_radius_q8  = '0;

        fix_errors         = 0;
        fixes_checked      = 0;
        samples_taken      = 0;
        radius_writes      = 0;
        idle_cycles        = 0;
        src_gap_max        = MAX_GAP;
        rcv_gap_max        = MAX_GAP;
        result_hold_cycles = 0;
        walk_a             = 16'd0;
        walk_b             = 16'd0;
        walk_h             = 0;

        // The quarter-wave table: odd series through x^19 in Q30, every term
        // truncated, the sum clamped to 0..1.0 and rounded half up to TRIG_FRAC bits.
        for (int d = 0; d <= 90; d++) begin
            x    = longint'(d) * RAD_PER_DEG_Q30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 9; k++) begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1) begin
                    sum = sum - longint'(term);
                end
                else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > (longint'(1) << 30)) begin
                sum = longint'(1) << 30;
            end
            sine_tab[d] = (TRIG_FRAC+1)'((sum + (longint'(1) << (29 - TRIG_FRAC)))
                                        >>> (30 - TRIG_FRAC));
        end

        // Predictor state after reset.
        prev_a     = '0;
        prev_b     = '0;
        last_chg_a = 0;
        last_chg_b = 0;
        pos_x      = '0;
        pos_y      = '0;
        radius_q8  = RESET_RADIUS;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_still_wheels();
        test_wheel_extremes();
        test_heading_wrap();
        test_radius_settings();
        test_motion_random();
        test_result_backpressure();
        settle_block();

        $display("Ran %0d sample items and checked %0d results across %0d radius writes,",
                 samples_taken, fixes_checked, radius_writes);
        $display("with headings in every quadrant, idle wheels and a long output stall.");
        if (fix_errors == 0 && pending_fixes.size() == 0) begin
            $display("Regression PASS");
        end
        else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
